// ===== sv/klfe_pkg.sv =====
// Shared constants, types and arithmetic helpers for the key LED fade engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package klfe_pkg;

  localparam int ROWS   = 6;
  localparam int COLS   = 17;
  localparam int DEPTH  = ROWS * COLS;
  localparam int IDX_W  = $clog2(DEPTH);

  localparam int ROW_W  = 3;
  localparam int COL_W  = 5;
  localparam int STEP_W = 4;
  localparam int HOST_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_USER_STEP        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDICATOR_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_INDEX       = 2'd2;

  localparam logic [7:0] LEVEL_FULL = 8'hff;

  // Indicator keys sit on this row, over this column span.
  localparam logic [ROW_W-1:0] IND_ROW     = 3'd1;
  localparam logic [COL_W-1:0] IND_COL_LO  = 5'd1;
  localparam logic [COL_W-1:0] IND_COL_HI  = 5'd3;

  // Fade level of one key after its stored level is looked up and updated.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       level;
  } lvl_item_t;

  // Settings that shape the color of a key.
  typedef struct packed {
    logic [STEP_W-1:0] user_step;
    logic              indicator_enable;
    logic [HOST_W-1:0] host_index;
  } color_cfg_t;

  // Base brightness for a step; out-of-range steps clamp to 1 or 10.
  function automatic logic [7:0] base_level(input logic [STEP_W-1:0] step);
    logic [7:0] b;
    case (step)
      4'd0, 4'd1: b = 8'd10;
      4'd2:       b = 8'd37;
      4'd3:       b = 8'd64;
      4'd4:       b = 8'd91;
      4'd5:       b = 8'd118;
      4'd6:       b = 8'd146;
      4'd7:       b = 8'd173;
      4'd8:       b = 8'd200;
      4'd9:       b = 8'd227;
      default:    b = 8'd255;
    endcase
    return b;
  endfunction

  // One release step: subtract (270 - lv) / 15, clamped at zero.
  // The divide by 15 is x * 137 >> 11, exact for x up to 270.
  function automatic logic [7:0] faded(input logic [7:0] lv);
    logic [8:0]  x;
    logic [16:0] p;
    logic [7:0]  dec;
    x   = 9'd270 - {1'b0, lv};
    p   = {8'd0, x} * 17'd137;
    dec = {3'd0, p[15:11]};
    return (lv >= dec) ? (lv - dec) : 8'd0;
  endfunction

  // Floor of x / 255, exact for x below 65280.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // Linear store index of a key inside the matrix.
  function automatic logic [IDX_W-1:0] key_index(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    logic [8:0] full;
    full = 9'(row) * 9'(COLS) + 9'(col);
    return full[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/klfe_fade_store.sv =====
// Per-key fade level store: synchronous memory with a filled bit per key,
// read-modify-write with forwarding from the entry being written. Uses klfe_pkg.
`timescale 1ns / 1ps

module klfe_fade_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      take,
  input  logic [klfe_pkg::ROW_W-1:0] key_row,
  input  logic [klfe_pkg::COL_W-1:0] key_col,
  input  logic                      key_pressed,
  output klfe_pkg::lvl_item_t       lvl
);
  import klfe_pkg::*;

  logic [7:0]       mem [0:DEPTH-1];
  logic [DEPTH-1:0] filled;

  logic             in_range;
  logic [IDX_W-1:0] in_idx;

  // First stage: the key whose level is being read back.
  logic             s1_valid;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_pressed;
  logic             s1_in_range;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_rdata;
  logic             s1_filled;
  logic             s1_fwd;
  logic [7:0]       s1_fwd_level;

  logic [7:0]       old_level;
  logic [7:0]       new_level;
  logic             do_write;

  assign in_range = (int'(key_row) < ROWS) && (int'(key_col) < COLS);
  assign in_idx   = in_range ? key_index(key_row, key_col) : '0;

  assign old_level = s1_fwd    ? s1_fwd_level :
                     s1_filled ? s1_rdata     : 8'd0;

  always_comb begin
    if (!s1_in_range) begin
      new_level = s1_pressed ? LEVEL_FULL : 8'd0;
    end else if (s1_pressed) begin
      new_level = LEVEL_FULL;
    end else if (old_level == 8'd0) begin
      new_level = 8'd0;
    end else begin
      new_level = faded(old_level);
    end
  end

  // The key in the first stage writes back as it moves on.
  assign do_write = advance && s1_valid && s1_in_range;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[s1_idx] <= new_level;
    end
    if (take) begin
      s1_rdata <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      s1_valid  <= 1'b0;
      s1_filled <= 1'b0;
      s1_fwd    <= 1'b0;
    end else begin
      if (do_write) begin
        filled[s1_idx] <= 1'b1;
      end
      if (advance) begin
        s1_valid <= take;
      end
      if (take) begin
        s1_filled <= filled[in_idx];
        // The same key may be written at this very edge; take its new level.
        s1_fwd    <= do_write && in_range && (s1_idx == in_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_row       <= key_row;
      s1_col       <= key_col;
      s1_pressed   <= key_pressed;
      s1_in_range  <= in_range;
      s1_idx       <= in_idx;
      s1_fwd_level <= new_level;
    end
  end

  assign lvl.valid = s1_valid;
  assign lvl.row   = s1_row;
  assign lvl.col   = s1_col;
  assign lvl.level = new_level;

endmodule

// ===== sv/klfe_color.sv =====
// Color stage: level times brightness products, then divide by 255 and the
// indicator override into the output register. Uses klfe_pkg.
`timescale 1ns / 1ps

module klfe_color (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  klfe_pkg::lvl_item_t        lvl,
  input  klfe_pkg::color_cfg_t       cfg,
  output logic                       out_valid,
  output logic [klfe_pkg::ROW_W-1:0] led_row,
  output logic [klfe_pkg::COL_W-1:0] led_col,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue
);
  import klfe_pkg::*;

  logic [7:0]       base;
  logic             ovr;

  logic             s2_valid;
  logic [ROW_W-1:0] s2_row;
  logic [COL_W-1:0] s2_col;
  logic [7:0]       s2_base;
  logic [15:0]      s2_prod_r;
  logic [15:0]      s2_prod_g;
  logic             s2_ovr;

  logic [7:0]       r_calc;
  logic [7:0]       g_calc;

  assign base = base_level(cfg.user_step);
  assign ovr  = cfg.indicator_enable && (lvl.row == IND_ROW) &&
                (lvl.col >= IND_COL_LO) && (lvl.col <= IND_COL_HI) &&
                (lvl.col == {3'd0, cfg.host_index});

  assign r_calc = s2_base + div255(s2_prod_r);
  assign g_calc = s2_base - div255(s2_prod_g);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s2_valid  <= lvl.valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_row    <= lvl.row;
      s2_col    <= lvl.col;
      s2_base   <= base;
      s2_prod_r <= {8'd0, lvl.level} * {8'd0, 8'd255 - base};
      s2_prod_g <= {8'd0, lvl.level} * {8'd0, base};
      s2_ovr    <= ovr;
      led_row   <= s2_row;
      led_col   <= s2_col;
      red       <= s2_ovr ? 8'd0   : r_calc;
      green     <= s2_ovr ? 8'd0   : g_calc;
      blue      <= s2_ovr ? 8'd255 : g_calc;
    end
  end

endmodule

// ===== sv/key_led_fade_engine.sv =====
// Key LED fade engine top level: configuration registers, pipeline control.
// Depends on klfe_pkg, klfe_fade_store and klfe_color.
//
// Usage:
//   Input channel (in_valid, in_stall, key_row, key_col, key_pressed) takes one
//   key scan result per transfer. Output channel (out_valid, out_stall,
//   led_row, led_col, red, green, blue) gives exactly one color per key, in order.
//   The configuration port writes user_step (index 0), indicator_enable
//   (index 1) and host_index (index 2) on any edge with cfg_write high; other
//   indexes are ignored. Write it only while no key is in flight.
//   An input transfer passes the s1, s2 and output registers to out_valid.
//   Throughput is one key per cycle unless the output stalls: the three-stage
//   pipeline reads the fade store as a key enters the first stage and writes
//   it back as it leaves; a repeat of the previous key is served by forwarding.
//   Reset clears all fade levels at once (a filled flag per key), sets
//   user_step to 2 and the other registers to 0.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   in_stall rises; a free output register keeps the pipeline moving.
`timescale 1ns / 1ps

module key_led_fade_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [klfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [klfe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [klfe_pkg::ROW_W-1:0]      key_row,
  input  logic [klfe_pkg::COL_W-1:0]      key_col,
  input  logic                            key_pressed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [klfe_pkg::ROW_W-1:0]      led_row,
  output logic [klfe_pkg::COL_W-1:0]      led_col,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue
);
  import klfe_pkg::*;

  color_cfg_t cfg;
  lvl_item_t  lvl;
  logic       advance;
  logic       take;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign take     = advance && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_step        <= 4'd2;
      cfg.indicator_enable <= 1'b0;
      cfg.host_index       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_USER_STEP:        cfg.user_step        <= cfg_data[STEP_W-1:0];
        REG_INDICATOR_ENABLE: cfg.indicator_enable <= cfg_data[0];
        REG_HOST_INDEX:       cfg.host_index       <= cfg_data[HOST_W-1:0];
        default: ;
      endcase
    end
  end

  klfe_fade_store u_store (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .take        (take),
    .key_row     (key_row),
    .key_col     (key_col),
    .key_pressed (key_pressed),
    .lvl         (lvl)
  );

  klfe_color u_color (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .lvl       (lvl),
    .cfg       (cfg),
    .out_valid (out_valid),
    .led_row   (led_row),
    .led_col   (led_col),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule
